// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/esf_pkg.sv
package esf_pkg;

  localparam int TS_W       = 63;
  localparam int FRAME_W    = 63;
  localparam int COUNT_W    = 13;
  localparam int ROLL_W     = 12;
  localparam int MAXLEN_W   = 16;
  localparam int DUR_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Item opcodes; the fourth code is unused and ignored
  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_FRAME = 2'd0;
  localparam opcode_t OP_START = 2'd1;
  localparam opcode_t OP_END   = 2'd2;

  // Configuration register indexes
  typedef logic [CFG_IDX_W-1:0] reg_index_t;
  localparam reg_index_t REG_PRE_ROLL  = 2'd0;
  localparam reg_index_t REG_POST_ROLL = 2'd1;
  localparam reg_index_t REG_MAX_LEN   = 2'd2;

  typedef struct packed {
    opcode_t         opcode;
    logic [TS_W-1:0] timestamp_ns;
  } item_t;

  typedef struct packed {
    logic [TS_W-1:0]    start_time_ns;
    logic [TS_W-1:0]    end_time_ns;
    logic [FRAME_W-1:0] first_frame;
    logic [COUNT_W-1:0] frame_count;
  } seg_t;

  typedef struct packed {
    logic [ROLL_W-1:0]   pre_roll_frames;
    logic [ROLL_W-1:0]   post_roll_frames;
    logic [MAXLEN_W-1:0] max_event_length;
  } cfg_t;

  typedef struct packed {
    logic event_open;
    logic finalize_pending;
  } status_t;

endpackage

// File: rtl/core/esf_item_if.sv
interface esf_item_if import esf_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// File: rtl/core/esf_seg_if.sv
interface esf_seg_if import esf_pkg::*; ();
  logic valid;
  logic ready;
  seg_t seg;

  modport source (output valid, output seg, input ready);
  modport sink (input valid, input seg, output ready);
endinterface

// File: rtl/core/event_segment_framer_top.sv
// Event segment framer. Takes frame-pushed, event-start and event-end items
// with nanosecond times on the events channel, one item per clock cycle, and
// gives one segment on the segments channel for each finished event: start
// and end times, first frame (start frame minus pre-roll, floored at zero) and
// frame count (at least one, clamped to MAX_SEGMENT_FRAMES). A segment comes
// out in the cycle after the frame push that completes its post-roll, through an
// output register; the events channel stalls whenever that register holds a
// segment that is not being taken in the same cycle, and otherwise takes items
// back to back. All tracking state updates in the single cycle in which an
// item is accepted, which sets the rate at one item per cycle. Write registers
// through cfg_wr_en, cfg_index and cfg_data only while the block is idle (the
// block itself does not enforce this); no clearing pass after reset.
`include "assert_macros.svh"

module event_segment_framer_top import esf_pkg::*; #(
  parameter int MAX_SEGMENT_FRAMES = 5000
) (
  input  logic                  clk,
  input  logic                  rst,
  esf_item_if.sink              events,
  esf_seg_if.source             segments,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  status_t status;
  logic    accept;
  logic    res_valid;
  seg_t    res;
  logic    seg_valid;
  seg_t    seg_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pre_roll_frames  <= '0;
      cfg.post_roll_frames <= '0;
      cfg.max_event_length <= MAXLEN_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PRE_ROLL:  cfg.pre_roll_frames  <= cfg_data[ROLL_W-1:0];
        REG_POST_ROLL: cfg.post_roll_frames <= cfg_data[ROLL_W-1:0];
        REG_MAX_LEN:   cfg.max_event_length <= cfg_data[MAXLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Take an item whenever the output register can move
  assign events.ready = !seg_valid || segments.ready;
  assign accept       = events.valid && events.ready;

  esf_tracker #(
    .MAX_SEGMENT_FRAMES(MAX_SEGMENT_FRAMES)
  ) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (events.item),
    .cfg       (cfg),
    .status    (status),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register: load a new segment, or drop the taken one
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (res_valid) begin
      seg_valid <= 1'b1;
    end else if (segments.ready) begin
      seg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      seg_data <= res;
    end
  end

  assign segments.valid = seg_valid;
  assign segments.seg   = seg_data;

  `ASSERT_IMPL(a_open_pending_excl, clk, rst, status.event_open, !status.finalize_pending)
  `ASSERT_IMPL(a_seg_on_frame, clk, rst, res_valid, accept && (events.item.opcode == OP_FRAME))
  `ASSERT_IMPL(a_count_nonzero, clk, rst, seg_valid, seg_data.frame_count != '0)
  `ASSERT_NEXT(a_seg_loaded, clk, rst, res_valid, seg_valid && (seg_data == $past(res)))

endmodule

// File: rtl/core/esf_tracker.sv
module esf_tracker import esf_pkg::*; #(
  parameter int MAX_SEGMENT_FRAMES = 5000
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  item_t   item,
  input  cfg_t    cfg,
  output status_t status,
  output logic    res_valid,
  output seg_t    res
);

  logic [FRAME_W-1:0]  frame_counter;
  logic                event_open;
  logic                finalize_pending;
  logic [FRAME_W-1:0]  event_start_frame;
  logic [TS_W-1:0]     event_start_time;
  logic [TS_W-1:0]     event_end_time;
  logic [DUR_W-1:0]    dur_count;
  logic [ROLL_W-1:0]   wait_count;
  logic [DUR_W-1:0]    span_base;

  logic                is_frame;
  logic                is_start;
  logic                is_end;
  logic [FRAME_W-1:0]  frame_inc;
  logic [DUR_W-1:0]    dur_inc;
  logic [MAXLEN_W-1:0] limit;
  logic                force_close;
  logic                end_close;
  logic [DUR_W-1:0]    close_base;
  logic                finalize;
  logic [DUR_W-1:0]    base_sel;
  logic [ROLL_W-1:0]   pre_used;
  logic [DUR_W-1:0]    span;
  logic [DUR_W-1:0]    span_min;
  logic [DUR_W-1:0]    span_clamped;

  // Decode the item
  assign is_frame = accept && (item.opcode == OP_FRAME);
  assign is_start = accept && (item.opcode == OP_START) && !event_open && !finalize_pending;
  assign is_end   = accept && (item.opcode == OP_END);

  // Frame and duration counters, duration kept relative to the start frame
  assign frame_inc = frame_counter + FRAME_W'(1);
  assign dur_inc   = dur_count + DUR_W'(1);
  assign limit     = (cfg.max_event_length == '0) ? MAXLEN_W'(1) : cfg.max_event_length;

  // Close on overlong event or on an end item
  assign force_close = is_frame && event_open && (dur_inc > DUR_W'(limit));
  assign end_close   = is_end && event_open;
  assign close_base  = (force_close ? dur_inc : dur_count) + DUR_W'(cfg.post_roll_frames);

  // Finalize once the post-roll countdown runs out, or on a forced close with no post-roll
  assign finalize = is_frame &&
                    ((finalize_pending && (wait_count <= ROLL_W'(1))) ||
                     (force_close && (cfg.post_roll_frames == '0)));

  // Segment span: (finalize frame - start frame) + min(pre-roll, start frame)
  assign base_sel = force_close ? close_base : span_base;
  assign pre_used = (event_start_frame >= FRAME_W'(cfg.pre_roll_frames)) ?
                    cfg.pre_roll_frames : event_start_frame[ROLL_W-1:0];
  assign span     = base_sel + DUR_W'(pre_used);
  assign span_min = (span == '0) ? DUR_W'(1) : span;
  assign span_clamped = (span_min > DUR_W'(MAX_SEGMENT_FRAMES)) ?
                        DUR_W'(MAX_SEGMENT_FRAMES) : span_min;

  // Result
  assign res_valid         = finalize;
  assign res.start_time_ns = event_start_time;
  assign res.end_time_ns   = force_close ? item.timestamp_ns : event_end_time;
  assign res.first_frame   = event_start_frame - FRAME_W'(pre_used);
  assign res.frame_count   = span_clamped[COUNT_W-1:0];

  assign status.event_open       = event_open;
  assign status.finalize_pending = finalize_pending;

  // Advance the tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter     <= '0;
      event_open        <= 1'b0;
      finalize_pending  <= 1'b0;
      event_start_frame <= '0;
      event_start_time  <= '0;
      event_end_time    <= '0;
      dur_count         <= '0;
      wait_count        <= '0;
      span_base         <= '0;
    end else begin
      if (is_frame) begin
        frame_counter <= frame_inc;
        if (event_open) begin
          dur_count <= dur_inc;
        end
        if (finalize_pending && !finalize) begin
          wait_count <= wait_count - ROLL_W'(1);
        end
      end
      if (is_start) begin
        event_open        <= 1'b1;
        event_start_time  <= item.timestamp_ns;
        event_start_frame <= frame_counter;
        dur_count         <= '0;
      end
      if (force_close || end_close) begin
        event_open       <= 1'b0;
        finalize_pending <= 1'b1;
        event_end_time   <= item.timestamp_ns;
        wait_count       <= cfg.post_roll_frames;
        span_base        <= close_base;
      end
      // Drop the finished event
      if (finalize) begin
        finalize_pending  <= 1'b0;
        event_start_frame <= '0;
        event_start_time  <= '0;
        event_end_time    <= '0;
      end
    end
  end

endmodule
